### hw/rtl/hmt_pkg.sv
// ----------------------------------------------------------------------------
// hmt_pkg: shared constants and types of the 4x4 homogeneous transform
// Fixed-point format, datapath widths, register codes and stage control.
// ----------------------------------------------------------------------------
`default_nettype none

package hmt_pkg;

   // fixed-point format of matrix entries, vector and result components
   localparam int FRAC_BITS = 16;
   localparam int WORD_W    = 32;
   localparam int DIM       = 4;

   // datapath widths: product, pair sum, four-term sum, shifted sum
   localparam int PROD_W = 2 * WORD_W;
   localparam int PAIR_W = PROD_W + 1;
   localparam int SUM_W  = PROD_W + 2;
   localparam int Q_W    = SUM_W - FRAC_BITS;

   // pipeline depth from the request register to the response register
   localparam int STAGES = 5;

   // configuration registers
   localparam int REG_COUNT = 8;
   localparam int IDX_W     = $clog2(REG_COUNT);
   localparam int CSR_W     = 2 * WORD_W;

   localparam logic [IDX_W-1:0] ROW1_COLS12 = IDX_W'(0);
   localparam logic [IDX_W-1:0] ROW1_COLS34 = IDX_W'(1);
   localparam logic [IDX_W-1:0] ROW2_COLS12 = IDX_W'(2);
   localparam logic [IDX_W-1:0] ROW2_COLS34 = IDX_W'(3);
   localparam logic [IDX_W-1:0] ROW3_COLS12 = IDX_W'(4);
   localparam logic [IDX_W-1:0] ROW3_COLS34 = IDX_W'(5);
   localparam logic [IDX_W-1:0] ROW4_COLS12 = IDX_W'(6);
   localparam logic [IDX_W-1:0] ROW4_COLS34 = IDX_W'(7);

   // 1.0 in the entry format and the identity rows
   localparam logic [WORD_W-1:0] FX_ONE   = WORD_W'(1) << FRAC_BITS;
   localparam logic [CSR_W-1:0]  DIAG_HI  = {FX_ONE, {WORD_W{1'b0}}};
   localparam logic [CSR_W-1:0]  DIAG_LO  = {{WORD_W{1'b0}}, FX_ONE};
   localparam logic [CSR_W-1:0]  REG_ZERO = '0;

   // saturation limits
   localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   // request kinds
   typedef enum logic {
      REQ_COLUMN = 1'b0,
      REQ_ROW    = 1'b1
   } req_kind_type;

   // per-stage load enables of a lane
   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } stage_en_type;

endpackage

`default_nettype wire

### hw/rtl/hmt_lane.sv
// ----------------------------------------------------------------------------
// hmt_lane: one result component
// Four signed products, a registered adder tree, then round, shift and clip.
// ----------------------------------------------------------------------------
`default_nettype none

module hmt_lane (
   input  wire logic                                 clock,
   input  wire hmt_pkg::stage_en_type                en,
   input  wire logic signed [hmt_pkg::WORD_W-1:0]    mat_a [hmt_pkg::DIM],
   input  wire logic signed [hmt_pkg::WORD_W-1:0]    vec_b [hmt_pkg::DIM],
   output logic signed      [hmt_pkg::WORD_W-1:0]    result,
   output logic                                      sat
);

   localparam logic signed [hmt_pkg::SUM_W-1:0] ROUND_HALF =
      hmt_pkg::SUM_W'(1) << (hmt_pkg::FRAC_BITS - 1);

   logic signed [hmt_pkg::PROD_W-1:0] prod_ff [hmt_pkg::DIM];
   logic signed [hmt_pkg::PAIR_W-1:0] pair_ff [2];
   logic signed [hmt_pkg::SUM_W-1:0]  sum_ff;
   logic signed [hmt_pkg::WORD_W-1:0] result_ff, result_in;
   logic                              sat_ff, sat_in;

   logic signed [hmt_pkg::SUM_W-1:0]  rounded;
   logic signed [hmt_pkg::Q_W-1:0]    shifted;
   logic [hmt_pkg::Q_W-hmt_pkg::WORD_W:0] upper;

   // multiply each matrix entry by its vector component
   always_ff @(posedge clock) begin
      if (en.s2) begin
         for (int k = 0; k < hmt_pkg::DIM; k++) begin
            prod_ff[k] <= hmt_pkg::PROD_W'(mat_a[k]) * hmt_pkg::PROD_W'(vec_b[k]);
         end
      end
   end

   // add products in pairs
   always_ff @(posedge clock) begin
      if (en.s3) begin
         pair_ff[0] <= hmt_pkg::PAIR_W'(prod_ff[0]) + hmt_pkg::PAIR_W'(prod_ff[1]);
         pair_ff[1] <= hmt_pkg::PAIR_W'(prod_ff[2]) + hmt_pkg::PAIR_W'(prod_ff[3]);
      end
   end

   // exact four-term sum
   always_ff @(posedge clock) begin
      if (en.s4) begin
         sum_ff <= hmt_pkg::SUM_W'(pair_ff[0]) + hmt_pkg::SUM_W'(pair_ff[1]);
      end
   end

   // round half up, drop the fraction, clip to one word
   always_comb begin
      rounded   = sum_ff + ROUND_HALF;
      shifted   = rounded[hmt_pkg::SUM_W-1:hmt_pkg::FRAC_BITS];
      upper     = shifted[hmt_pkg::Q_W-1:hmt_pkg::WORD_W-1];
      sat_in    = !((&upper) || !(|upper));
      result_in = shifted[hmt_pkg::WORD_W-1:0];
      if (sat_in) begin
         result_in = shifted[hmt_pkg::Q_W-1] ? hmt_pkg::WORD_MIN : hmt_pkg::WORD_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s5) begin
         result_ff <= result_in;
         sat_ff    <= sat_in;
      end
   end

   assign result = result_ff;
   assign sat    = sat_ff;

endmodule

`default_nettype wire

### hw/rtl/homogeneous_matrix_transform_core.sv
// ----------------------------------------------------------------------------
// homogeneous_matrix_transform_core: 4x4 matrix times vector, Q16.16
// Column product M*v or row product v*M with rounding and saturation.
// ----------------------------------------------------------------------------
// The block takes one request per clock when the response side keeps up. The
// pipeline is five register stages: operand selection from the matrix, sixteen
// parallel 32x32 multipliers, two adder-tree levels, and a round/shift/clip
// stage that feeds the response register. Every stage carries its own valid
// bit, so a stall on the response side fills empty stages first and only then
// drops req_tready. The matrix lives in eight 64-bit registers written through
// the csr port; the user must write them only while no request is in flight,
// the block itself does not enforce this. Reset loads the identity matrix.
`default_nettype none

module homogeneous_matrix_transform_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [4*hmt_pkg::WORD_W-1:0]  req_tdata,  // in_x, in_y, in_z, in_w
   input  wire logic [0:0]                    req_tuser,  // req_type
   // response channel
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [4*hmt_pkg::WORD_W-1:0]       rsp_tdata,  // out_x, out_y, out_z, out_w
   output logic [0:0]                         rsp_tuser,  // saturated
   // configuration port
   input  wire logic                          csr_we,
   input  wire logic [hmt_pkg::IDX_W-1:0]     csr_index,
   input  wire logic [hmt_pkg::CSR_W-1:0]     csr_wdata
);

   localparam int W = hmt_pkg::WORD_W;
   localparam int N = hmt_pkg::DIM;

   logic [hmt_pkg::CSR_W-1:0] mat_ff [hmt_pkg::REG_COUNT];

   logic [hmt_pkg::STAGES:1]   valid_ff, valid_in;
   logic [hmt_pkg::STAGES+1:1] free;

   logic signed [W-1:0] opa_ff [N][N];
   logic signed [W-1:0] opa_in [N][N];
   logic signed [W-1:0] vec_ff [N];
   logic signed [W-1:0] lane_result [N];
   logic [N-1:0]        lane_sat;

   hmt_pkg::stage_en_type stage_en;
   hmt_pkg::req_kind_type req_kind;

   // hold the matrix registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff[hmt_pkg::ROW1_COLS12] <= hmt_pkg::DIAG_HI;
         mat_ff[hmt_pkg::ROW1_COLS34] <= hmt_pkg::REG_ZERO;
         mat_ff[hmt_pkg::ROW2_COLS12] <= hmt_pkg::DIAG_LO;
         mat_ff[hmt_pkg::ROW2_COLS34] <= hmt_pkg::REG_ZERO;
         mat_ff[hmt_pkg::ROW3_COLS12] <= hmt_pkg::REG_ZERO;
         mat_ff[hmt_pkg::ROW3_COLS34] <= hmt_pkg::DIAG_HI;
         mat_ff[hmt_pkg::ROW4_COLS12] <= hmt_pkg::REG_ZERO;
         mat_ff[hmt_pkg::ROW4_COLS34] <= hmt_pkg::DIAG_LO;
      end else if (csr_we) begin
         mat_ff[csr_index] <= csr_wdata;
      end
   end

   // a stage can load when it is empty or its content moves on
   always_comb begin
      free[hmt_pkg::STAGES+1] = rsp_tready;
      for (int s = hmt_pkg::STAGES; s >= 1; s--) begin
         free[s] = !valid_ff[s] || free[s+1];
      end
      valid_in[1] = free[1] ? req_tvalid : valid_ff[1];
      for (int s = 2; s <= hmt_pkg::STAGES; s++) begin
         valid_in[s] = free[s] ? valid_ff[s-1] : valid_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready  = free[1];
   assign stage_en.s2 = free[2];
   assign stage_en.s3 = free[3];
   assign stage_en.s4 = free[4];
   assign stage_en.s5 = free[5];

   // pick the matrix entries each lane needs: row i for a column product,
   // column i for a row product; even columns sit in the upper half
   assign req_kind = hmt_pkg::req_kind_type'(req_tuser[0]);

   always_comb begin
      logic [hmt_pkg::IDX_W-1:0] idx;
      logic                      upper_half;
      for (int i = 0; i < N; i++) begin
         for (int k = 0; k < N; k++) begin
            unique case (req_kind)
               hmt_pkg::REQ_COLUMN: begin
                  idx        = hmt_pkg::IDX_W'((i << 1) + (k >> 1));
                  upper_half = ((k & 1) == 0);
               end
               hmt_pkg::REQ_ROW: begin
                  idx        = hmt_pkg::IDX_W'((k << 1) + (i >> 1));
                  upper_half = ((i & 1) == 0);
               end
               default: begin
                  idx        = hmt_pkg::ROW1_COLS12;
                  upper_half = 1'b1;
               end
            endcase
            opa_in[i][k] = upper_half ? mat_ff[idx][2*W-1:W] : mat_ff[idx][W-1:0];
         end
      end
   end

   // register the selected operands and the vector
   always_ff @(posedge clock) begin
      if (free[1]) begin
         opa_ff <= opa_in;
         for (int k = 0; k < N; k++) begin
            vec_ff[k] <= req_tdata[k*W +: W];
         end
      end
   end

   // one lane per result component
   for (genvar i = 0; i < N; i++) begin : g_lane
      hmt_lane u_lane (
         .clock  (clock),
         .en     (stage_en),
         .mat_a  (opa_ff[i]),
         .vec_b  (vec_ff),
         .result (lane_result[i]),
         .sat    (lane_sat[i])
      );
   end

   // drive the response
   assign rsp_tvalid = valid_ff[hmt_pkg::STAGES];
   always_comb begin
      for (int i = 0; i < N; i++) begin
         rsp_tdata[i*W +: W] = lane_result[i];
      end
   end
   assign rsp_tuser[0] = |lane_sat;

   // an accepted request occupies the first stage
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> valid_ff[1])
      else $error("accepted request did not enter the pipeline");

   // a stage that cannot move on keeps its item
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] && !free[4] |=> valid_ff[3])
      else $error("stalled item dropped from stage three");

   // a saturated response carries at least one clipped component
   a_sat_clipped: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         (lane_result[0] == hmt_pkg::WORD_MAX) || (lane_result[0] == hmt_pkg::WORD_MIN) ||
         (lane_result[1] == hmt_pkg::WORD_MAX) || (lane_result[1] == hmt_pkg::WORD_MIN) ||
         (lane_result[2] == hmt_pkg::WORD_MAX) || (lane_result[2] == hmt_pkg::WORD_MIN) ||
         (lane_result[3] == hmt_pkg::WORD_MAX) || (lane_result[3] == hmt_pkg::WORD_MIN))
      else $error("saturation flag without a clipped component");

   // with the first stage empty the request side is open
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[1] |-> req_tready)
      else $error("request side stalled with an empty first stage");

endmodule

`default_nettype wire

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for homogeneous_matrix_transform_core
// Streams column and row vector requests through the core under several
// matrix settings, random request gaps and response back-pressure, predicts
// every response with an exact 66-bit dot product, and checks it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import hmt_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int RAND_PHASES   = 20;
   localparam int PHASE_LENGTH  = 62;

   // pending stimulus: requests, register writes, drain points, pace changes
   typedef enum logic [1:0] {
      OP_REQUEST,
      OP_CSR,
      OP_DRAIN,
      OP_PACE
   } stim_kind_type;

   typedef struct {
      stim_kind_type          kind;
      req_kind_type           mode;
      logic [4*WORD_W-1:0]    vec;      // w, z, y, x from the top down
      logic [IDX_W-1:0]       index;
      logic [CSR_W-1:0]       value;
      int unsigned            send_idle;
      int unsigned            recv_stall;
   } stim_op_type;

   typedef struct {
      logic [4*WORD_W-1:0] comps;
      logic                sat;
   } xform_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [4*WORD_W-1:0]   req_tdata  = '0;   // in_x, in_y, in_z, in_w
   logic [0:0]            req_tuser  = '0;   // req_type
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [4*WORD_W-1:0]   rsp_tdata;         // out_x, out_y, out_z, out_w
   logic [0:0]            rsp_tuser;         // saturated
   logic                  csr_we     = 1'b0;
   logic [IDX_W-1:0]      csr_index  = '0;
   logic [CSR_W-1:0]      csr_wdata  = '0;

   stim_op_type           stim_queue[$];
   xform_result_type      expected_results[$];
   logic [CSR_W-1:0]      matrix_regs[REG_COUNT];

   int unsigned           send_idle_pct   = 0;
   int unsigned           recv_stall_pct  = 0;
   int unsigned           sent_count      = 0;
   int unsigned           recv_count      = 0;
   logic                  stim_done       = 1'b0;
   int unsigned           error_count     = 0;
   int unsigned           column_count    = 0;
   int unsigned           row_count       = 0;
   int unsigned           sat_count       = 0;
   int unsigned           csr_write_count = 0;
   int unsigned           cycle_count     = 0;

   homogeneous_matrix_transform_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // Exact transform of one vector by the mirrored matrix: each lane sums
   // four 64-bit products in 66 bits, adds half an LSB, floors, then clips.
   function automatic xform_result_type compute_transform(input req_kind_type mode,
                                                          input logic [4*WORD_W-1:0] vec);
      xform_result_type        res;
      logic signed [SUM_W-1:0] acc;
      logic signed [SUM_W-1:0] quot;
      logic signed [PROD_W-1:0] prod;
      logic signed [WORD_W-1:0] ent;
      logic signed [WORD_W-1:0] comp;
      logic [CSR_W-1:0]        pair;
      int                      row;
      int                      col;
      res.sat = 1'b0;
      res.comps = '0;
      for (int lane = 0; lane < DIM; lane++) begin
         acc = SUM_W'(1) <<< (FRAC_BITS - 1);
         for (int k = 0; k < DIM; k++) begin
            row  = (mode == REQ_ROW) ? k : lane;
            col  = (mode == REQ_ROW) ? lane : k;
            pair = matrix_regs[row * 2 + col / 2];
            ent  = col[0] ? pair[WORD_W-1:0] : pair[CSR_W-1:WORD_W];
            comp = vec[k*WORD_W +: WORD_W];
            prod = ent * comp;
            acc  = acc + prod;
         end
         quot = acc >>> FRAC_BITS;
         if (quot > 66'sd2147483647) begin
            res.comps[lane*WORD_W +: WORD_W] = WORD_MAX;
            res.sat = 1'b1;
         end else if (quot < -66'sd2147483648) begin
            res.comps[lane*WORD_W +: WORD_W] = WORD_MIN;
            res.sat = 1'b1;
         end else begin
            res.comps[lane*WORD_W +: WORD_W] = quot[WORD_W-1:0];
         end
      end
      return res;
   endfunction

   // Mix of small fractions, whole numbers, full-range words and extremes.
   function automatic logic [WORD_W-1:0] rand_fixed();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 40) begin
         return $urandom_range(32'h80000) - 32'h40000;
      end else if (pick < 65) begin
         return $urandom;
      end else if (pick < 80) begin
         return ($urandom_range(16) - 8) << FRAC_BITS;
      end
      case ($urandom_range(6))
         0: return WORD_MAX;
         1: return WORD_MIN;
         2: return '0;
         3: return FX_ONE;
         4: return -FX_ONE;
         5: return WORD_W'(1);
         default: return '1;
      endcase
   endfunction

   task automatic push_request(input req_kind_type mode, input logic [WORD_W-1:0] x,
                               input logic [WORD_W-1:0] y, input logic [WORD_W-1:0] z,
                               input logic [WORD_W-1:0] w);
      stim_op_type op;
      op = '{kind: OP_REQUEST, mode: mode, vec: {w, z, y, x}, index: '0, value: '0,
             send_idle: 0, recv_stall: 0};
      stim_queue.push_back(op);
   endtask

   task automatic push_csr(input logic [IDX_W-1:0] index, input logic [CSR_W-1:0] value);
      stim_op_type op;
      op = '{kind: OP_CSR, mode: REQ_COLUMN, vec: '0, index: index, value: value,
             send_idle: 0, recv_stall: 0};
      stim_queue.push_back(op);
   endtask

   task automatic push_marker(input stim_kind_type kind, input int unsigned send_idle,
                              input int unsigned recv_stall);
      stim_op_type op;
      op = '{kind: kind, mode: REQ_COLUMN, vec: '0, index: '0, value: '0,
             send_idle: send_idle, recv_stall: recv_stall};
      stim_queue.push_back(op);
   endtask

   task automatic fill_matrix(input logic [CSR_W-1:0] value);
      for (int r = 0; r < REG_COUNT; r++) begin
         push_csr(IDX_W'(r), value);
      end
   endtask

   // Build the whole stimulus list up front.
   initial begin
      logic [WORD_W-1:0] wcomp;
      push_marker(OP_PACE, 23, 81);

      // identity matrix straight out of reset
      push_request(REQ_COLUMN, 32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, FX_ONE);
      push_request(REQ_ROW, WORD_MAX, WORD_MIN, '1, WORD_W'(1));
      push_request(REQ_COLUMN, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
      push_request(REQ_ROW, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);

      // asymmetric matrix so column and row products differ
      push_marker(OP_DRAIN, 0, 0);
      push_csr(ROW1_COLS12, {32'h0002_0000, 32'hFFFF_8000});
      push_csr(ROW1_COLS34, {32'h0000_4000, 32'h0003_0000});
      push_csr(ROW2_COLS12, {32'hFFFE_0000, 32'h0001_0000});
      push_csr(ROW2_COLS34, {32'h0000_0001, 32'h7FFF_FFFF});
      push_csr(ROW3_COLS12, {32'h8000_0000, 32'h0000_0000});
      push_csr(ROW3_COLS34, {32'h0001_8000, 32'hFFFF_FFFF});
      push_csr(ROW4_COLS12, {32'h0000_0000, 32'h0005_0000});
      push_csr(ROW4_COLS34, {32'h1234_5678, 32'h0001_0000});
      push_request(REQ_COLUMN, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000);
      push_request(REQ_ROW, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000);

      // all entries at the positive limit: clip both ways
      fill_matrix({WORD_MAX, WORD_MAX});
      push_request(REQ_COLUMN, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
      push_request(REQ_ROW, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
      push_request(REQ_COLUMN, '0, '0, '0, '0);

      // all entries at the negative limit: the four-term sum needs 66 bits
      fill_matrix({WORD_MIN, WORD_MIN});
      push_request(REQ_COLUMN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
      push_request(REQ_ROW, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
      push_request(REQ_COLUMN, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN);

      // one-LSB entries: exercise round half up on exact ties
      fill_matrix({32'h0000_0001, 32'h0000_0001});
      push_request(REQ_COLUMN, 32'h0000_8000, '0, '0, '0);
      push_request(REQ_COLUMN, 32'hFFFF_8000, '0, '0, '0);
      push_request(REQ_ROW, 32'h0000_7FFF, '0, '0, '0);
      push_request(REQ_ROW, 32'hFFFF_7FFF, '0, '0, '0);
      push_request(REQ_COLUMN, 32'h0000_4000, 32'h0000_4000, 32'h0000_4000, 32'h0000_4000);

      // random phases: fresh registers, then a run of random requests
      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         if (phase == RAND_PHASES / 3) begin
            push_marker(OP_PACE, 81, 23);
         end else if (phase == 2 * RAND_PHASES / 3) begin
            push_marker(OP_PACE, 0, 0);
         end
         for (int r = 0; r < REG_COUNT; r++) begin
            if ($urandom_range(9) < 7) begin
               push_csr(IDX_W'(r), {rand_fixed(), rand_fixed()});
            end
         end
         for (int n = 0; n < PHASE_LENGTH; n++) begin
            if ($urandom_range(49) == 0) begin
               push_marker(OP_DRAIN, 0, 0);
            end
            wcomp = ($urandom_range(9) < 3) ? FX_ONE : rand_fixed();
            push_request(req_kind_type'($urandom_range(1)), rand_fixed(), rand_fixed(),
                         rand_fixed(), wcomp);
         end
      end
   end

   // Driver: present requests, apply register writes and drain points only
   // once every accepted request has come back.
   always @(posedge clock) begin
      stim_op_type head;
      logic        accepted;
      logic        next_valid;
      logic        next_we;
      int unsigned sent_now;
      if (reset) begin
         req_tvalid <= 1'b0;
         csr_we     <= 1'b0;
         stim_done  <= 1'b0;
      end else begin
         accepted   = req_tvalid && req_tready;
         sent_now   = sent_count + (accepted ? 1 : 0);
         next_valid = req_tvalid && !accepted;
         next_we    = 1'b0;
         if (!next_valid && stim_queue.size() > 0) begin
            head = stim_queue[0];
            case (head.kind)
               OP_REQUEST: begin
                  if ($urandom_range(99) >= send_idle_pct) begin
                     void'(stim_queue.pop_front());
                     next_valid = 1'b1;
                     req_tdata <= head.vec;
                     req_tuser <= head.mode;
                  end
               end
               OP_CSR: begin
                  if (sent_now == recv_count) begin
                     void'(stim_queue.pop_front());
                     next_we = 1'b1;
                     csr_index <= head.index;
                     csr_wdata <= head.value;
                  end
               end
               OP_DRAIN: begin
                  if (sent_now == recv_count) begin
                     void'(stim_queue.pop_front());
                  end
               end
               default: begin
                  void'(stim_queue.pop_front());
                  send_idle_pct  <= head.send_idle;
                  recv_stall_pct <= head.recv_stall;
               end
            endcase
         end
         req_tvalid <= next_valid;
         csr_we     <= next_we;
         sent_count <= sent_now;
         stim_done  <= (stim_queue.size() == 0) && !next_valid && !next_we;
      end
   end

   // Monitor: predict on each accepted request, check each response in order,
   // and mirror register writes.
   always @(posedge clock) begin
      xform_result_type want;
      int unsigned      errs;
      errs = 0;
      if (reset) begin
         rsp_tready <= 1'b0;
         matrix_regs[ROW1_COLS12] <= DIAG_HI;
         matrix_regs[ROW1_COLS34] <= REG_ZERO;
         matrix_regs[ROW2_COLS12] <= DIAG_LO;
         matrix_regs[ROW2_COLS34] <= REG_ZERO;
         matrix_regs[ROW3_COLS12] <= REG_ZERO;
         matrix_regs[ROW3_COLS34] <= DIAG_HI;
         matrix_regs[ROW4_COLS12] <= REG_ZERO;
         matrix_regs[ROW4_COLS34] <= DIAG_LO;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         if (req_tvalid && req_tready) begin
            expected_results.push_back(compute_transform(req_kind_type'(req_tuser[0]),
                                                         req_tdata));
            if (req_tuser[0] == REQ_ROW) begin
               row_count <= row_count + 1;
            end else begin
               column_count <= column_count + 1;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            recv_count <= recv_count + 1;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected response, actual data %h sat %b",
                        $time, rsp_tdata, rsp_tuser[0]);
               errs = errs + 1;
            end else begin
               want = expected_results.pop_front();
               for (int lane = 0; lane < DIM; lane++) begin
                  if (rsp_tdata[lane*WORD_W +: WORD_W] !== want.comps[lane*WORD_W +: WORD_W])
                  begin
                     $display("%0t: lane %0d mismatch, expected %h, actual %h", $time, lane,
                              want.comps[lane*WORD_W +: WORD_W],
                              rsp_tdata[lane*WORD_W +: WORD_W]);
                     errs = errs + 1;
                  end
               end
               if (rsp_tuser[0] !== want.sat) begin
                  $display("%0t: saturated flag mismatch, expected %b, actual %b",
                           $time, want.sat, rsp_tuser[0]);
                  errs = errs + 1;
               end
               if (want.sat) begin
                  sat_count <= sat_count + 1;
               end
            end
         end
         if (csr_we) begin
            matrix_regs[csr_index] <= csr_wdata;
            csr_write_count <= csr_write_count + 1;
         end
         error_count <= error_count + errs;
      end
   end

   // Watchdog: stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d responses outstanding",
                  $time, cycle_count, sent_count - recv_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   // Wrap up once all stimulus is through and the pipeline has emptied.
   initial begin
      @(negedge reset);
      @(posedge clock);
      while (!(stim_done && sent_count == recv_count)) begin
         @(posedge clock);
      end
      repeat (4 * STAGES) @(posedge clock);
      if (expected_results.size() != 0) begin
         $display("%0t: %0d expected responses never arrived", $time, expected_results.size());
      end
      $display("Covered %0d column and %0d row requests across %0d register writes;",
               column_count, row_count, csr_write_count);
      $display("%0d responses clipped, %0d responses checked.", sat_count, recv_count);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire
